// ===== rtl/crc32_frame_encoder_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef CRC32_FRAME_ENCODER_UNIT_ASSERT_SVH
`define CRC32_FRAME_ENCODER_UNIT_ASSERT_SVH

// Clocked check, off while reset is high.
`define FE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds across reset.
`define FE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/crc32fe_pkg.sv =====
package crc32fe_pkg;

   localparam int unsigned LEN_W           = 13;
   localparam int unsigned MAX_PAYLOAD_DEF = 4096;
   localparam int unsigned IDX_W           = 4;

   localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

   localparam logic [7:0] MAGIC_0 = 8'h55;
   localparam logic [7:0] MAGIC_1 = 8'h66;
   localparam logic [7:0] MAGIC_2 = 8'hAA;
   localparam logic [7:0] MAGIC_3 = 8'hBB;
   localparam logic [7:0] CTRL_BYTE = 8'h01;

   // last header byte before the header CRC, last CRC byte
   localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(11);
   localparam logic [IDX_W-1:0] CRC_LAST = IDX_W'(3);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR,
      ST_HCRC,
      ST_DATA,
      ST_TCRC
   } state_type;

   typedef enum logic [1:0] {
      SRC_HDR,
      SRC_CRC,
      SRC_DATA_REG,
      SRC_DATA_IN
   } src_type;

   typedef struct packed {
      logic             capture;
      logic             emit;
      logic             dec;
      src_type          src;
      logic [IDX_W-1:0] idx;
      logic             frame_end;
      logic             item_end;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic left_zero;
      logic left_one;
   } status_type;

   // MSB-first CRC32 update over one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'h0};
      for (int i = 0; i < 8; i++) begin
         c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/crc32_frame_encoder_unit.sv =====
// A result beat is registered and shows on rsp_* in the cycle after the cycle that produces it.
// First item of a frame: the request is captured, then 17 beats (20 for an empty payload, 21 for
// one byte), one per cycle; req_ready stays low from the capture until the last beat is emitted.
// Later payload items: one per cycle; the last one adds 4 CRC beats, one per cycle.
// Each cycle with rsp_ready low while a beat waits stalls the flow.
// Synchronous reset clears the state machine, output valid, byte count and CRC.
module crc32_frame_encoder_unit #(
   parameter int unsigned MAX_PAYLOAD = crc32fe_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_cmd_id,
   input  logic [15:0]                   req_seq_num,
   input  logic [crc32fe_pkg::LEN_W-1:0] req_payload_len,
   input  logic [7:0]                    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_frame_end,
   output logic                          rsp_item_end
);

   crc32fe_pkg::cmd_type    cmd;
   crc32fe_pkg::status_type status;

   crc32fe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   crc32fe_dpath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd_id      (req_cmd_id),
      .req_seq_num     (req_seq_num),
      .req_payload_len (req_payload_len),
      .req_data_byte   (req_data_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_item_end    (rsp_item_end)
   );

endmodule

// ===== rtl/crc32fe_dpath.sv =====
module crc32fe_dpath #(
   parameter int unsigned MAX_PAYLOAD = crc32fe_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [7:0]                    req_cmd_id,
   input  logic [15:0]                   req_seq_num,
   input  logic [crc32fe_pkg::LEN_W-1:0] req_payload_len,
   input  logic [7:0]                    req_data_byte,
   input  crc32fe_pkg::cmd_type          cmd,
   output crc32fe_pkg::status_type       status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_frame_end,
   output logic                          rsp_item_end
);

   localparam int unsigned LW = crc32fe_pkg::LEN_W;

   logic [7:0]    cmd_id_ff;
   logic [15:0]   seq_ff;
   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    data_ff;
   logic [LW-1:0] left_ff, left_in;
   logic [31:0]   crc_ff, crc_in;
   logic [31:0]   snap_ff, snap_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          frame_end_ff, item_end_ff;

   logic [31:0] len32;
   logic [7:0]  hdr_byte;
   logic [7:0]  crc_sel;
   logic [31:0] crc_src;

   assign len32 = 32'(len_ff);

   always_comb begin
      unique case (cmd.idx)
         4'd0:    hdr_byte = crc32fe_pkg::MAGIC_0;
         4'd1:    hdr_byte = crc32fe_pkg::MAGIC_1;
         4'd2:    hdr_byte = crc32fe_pkg::MAGIC_2;
         4'd3:    hdr_byte = crc32fe_pkg::MAGIC_3;
         4'd4:    hdr_byte = crc32fe_pkg::CTRL_BYTE;
         4'd5:    hdr_byte = len32[7:0];
         4'd6:    hdr_byte = len32[15:8];
         4'd7:    hdr_byte = len32[23:16];
         4'd8:    hdr_byte = len32[31:24];
         4'd9:    hdr_byte = seq_ff[7:0];
         4'd10:   hdr_byte = seq_ff[15:8];
         4'd11:   hdr_byte = cmd_id_ff;
         default: hdr_byte = 8'h00;
      endcase
   end

   // first CRC byte reads the live accumulator, later ones the snapshot
   assign crc_src = (cmd.idx == '0) ? crc_ff : snap_ff;
   assign crc_sel = crc_src[8*cmd.idx[1:0] +: 8];

   always_comb begin
      unique case (cmd.src)
         crc32fe_pkg::SRC_HDR:      out_byte_in = hdr_byte;
         crc32fe_pkg::SRC_CRC:      out_byte_in = crc_sel;
         crc32fe_pkg::SRC_DATA_REG: out_byte_in = data_ff;
         crc32fe_pkg::SRC_DATA_IN:  out_byte_in = req_data_byte;
         default:                   out_byte_in = 8'h00;
      endcase
   end

   always_comb begin
      len_in  = len_ff;
      left_in = left_ff;
      crc_in  = crc_ff;
      snap_in = snap_ff;
      if (cmd.capture) begin
         len_in  = (32'(req_payload_len) > MAX_PAYLOAD) ? LW'(MAX_PAYLOAD) : req_payload_len;
         left_in = len_in;
         crc_in  = '0;
      end else if (cmd.emit) begin
         crc_in = crc32fe_pkg::crc_byte(crc_ff, out_byte_in);
         if (cmd.dec) begin
            left_in = left_ff - LW'(1);
         end
         if (cmd.src == crc32fe_pkg::SRC_CRC && cmd.idx == '0) begin
            snap_in = crc_ff;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
         crc_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
         crc_ff       <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      snap_ff <= snap_in;
      if (cmd.capture) begin
         cmd_id_ff <= req_cmd_id;
         seq_ff    <= req_seq_num;
         data_ff   <= req_data_byte;
      end
      if (cmd.emit) begin
         out_byte_ff  <= out_byte_in;
         frame_end_ff <= cmd.frame_end;
         item_end_ff  <= cmd.item_end;
      end
   end

   assign status.out_free  = !out_valid_ff || rsp_ready;
   assign status.left_zero = (left_ff == '0);
   assign status.left_one  = (left_ff == LW'(1));

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_frame_end = frame_end_ff;
   assign rsp_item_end  = item_end_ff;

endmodule

// ===== rtl/crc32fe_ctrl.sv =====
module crc32fe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  crc32fe_pkg::status_type status,
   output crc32fe_pkg::cmd_type    cmd
);

   localparam int unsigned IW = crc32fe_pkg::IDX_W;

   crc32fe_pkg::state_type state_ff, state_in;
   logic [IW-1:0]          cnt_ff, cnt_in;
   logic                   take;

   assign take = (state_ff == crc32fe_pkg::ST_IDLE) && req_valid && status.out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         crc32fe_pkg::ST_IDLE: begin
            if (take) begin
               cnt_in = '0;
               if (status.left_zero) begin
                  state_in = crc32fe_pkg::ST_HDR;
               end else if (status.left_one) begin
                  state_in = crc32fe_pkg::ST_TCRC;
               end
            end
         end
         crc32fe_pkg::ST_HDR: begin
            if (status.out_free) begin
               if (cnt_ff == crc32fe_pkg::HDR_LAST) begin
                  cnt_in   = '0;
                  state_in = crc32fe_pkg::ST_HCRC;
               end else begin
                  cnt_in = cnt_ff + IW'(1);
               end
            end
         end
         crc32fe_pkg::ST_HCRC: begin
            if (status.out_free) begin
               if (cnt_ff == crc32fe_pkg::CRC_LAST) begin
                  cnt_in   = '0;
                  state_in = status.left_zero ? crc32fe_pkg::ST_TCRC : crc32fe_pkg::ST_DATA;
               end else begin
                  cnt_in = cnt_ff + IW'(1);
               end
            end
         end
         crc32fe_pkg::ST_DATA: begin
            if (status.out_free) begin
               cnt_in   = '0;
               state_in = status.left_one ? crc32fe_pkg::ST_TCRC : crc32fe_pkg::ST_IDLE;
            end
         end
         crc32fe_pkg::ST_TCRC: begin
            if (status.out_free) begin
               if (cnt_ff == crc32fe_pkg::CRC_LAST) begin
                  cnt_in   = '0;
                  state_in = crc32fe_pkg::ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = crc32fe_pkg::ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   // commands
   always_comb begin
      req_ready     = 1'b0;
      cmd.capture   = 1'b0;
      cmd.emit      = 1'b0;
      cmd.dec       = 1'b0;
      cmd.src       = crc32fe_pkg::SRC_HDR;
      cmd.idx       = cnt_ff;
      cmd.frame_end = 1'b0;
      cmd.item_end  = 1'b0;
      unique case (state_ff)
         crc32fe_pkg::ST_IDLE: begin
            req_ready = status.out_free;
            if (take) begin
               if (status.left_zero) begin
                  cmd.capture = 1'b1;
               end else begin
                  // mid-frame payload byte goes straight out
                  cmd.emit     = 1'b1;
                  cmd.dec      = 1'b1;
                  cmd.src      = crc32fe_pkg::SRC_DATA_IN;
                  cmd.item_end = !status.left_one;
               end
            end
         end
         crc32fe_pkg::ST_HDR: begin
            cmd.emit = status.out_free;
            cmd.src  = crc32fe_pkg::SRC_HDR;
         end
         crc32fe_pkg::ST_HCRC: begin
            cmd.emit = status.out_free;
            cmd.src  = crc32fe_pkg::SRC_CRC;
         end
         crc32fe_pkg::ST_DATA: begin
            cmd.emit     = status.out_free;
            cmd.dec      = status.out_free;
            cmd.src      = crc32fe_pkg::SRC_DATA_REG;
            cmd.item_end = !status.left_one;
         end
         crc32fe_pkg::ST_TCRC: begin
            cmd.emit      = status.out_free;
            cmd.src       = crc32fe_pkg::SRC_CRC;
            cmd.frame_end = (cnt_ff == crc32fe_pkg::CRC_LAST);
            cmd.item_end  = (cnt_ff == crc32fe_pkg::CRC_LAST);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crc32fe_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/crc32fe_checker.sv =====
`include "crc32_frame_encoder_unit_assert.svh"

module crc32fe_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [7:0]                    req_cmd_id,
   input logic [15:0]                   req_seq_num,
   input logic [crc32fe_pkg::LEN_W-1:0] req_payload_len,
   input logic [7:0]                    req_data_byte,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [7:0]                    rsp_out_byte,
   input logic                          rsp_frame_end,
   input logic                          rsp_item_end
);

   // hold a stalled beat
   `FE_ASSERT(a_rsp_hold,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_frame_end) && $stable(rsp_item_end),
      "stalled rsp beat changed")

   // a waiting request beat keeps its payload
   `FE_ASSERT(a_req_hold,
      req_valid && !req_ready |=> req_valid && $stable(req_cmd_id) && $stable(req_seq_num)
         && $stable(req_payload_len) && $stable(req_data_byte),
      "stalled req beat changed")

   `FE_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "rsp_valid high after reset")

   // the frame's last CRC byte also closes its item
   `FE_ASSERT(a_frame_end_item, rsp_valid && rsp_frame_end |-> rsp_item_end,
      "frame_end without item_end")

   // input is taken only when the output slot frees up
   `FE_ASSERT(a_ready_slot, req_ready |-> !rsp_valid || rsp_ready,
      "req_ready while rsp stalled")

endmodule

bind crc32_frame_encoder_unit crc32fe_checker u_checker (.*);
